// ===== rtl/core/pgl_pkg.sv =====
// Shared constants, types and helper functions of the periodic grid Laplacian core.
package pgl_pkg;

  localparam int GRID_SIDE   = 32;
  localparam int GRID_DIMS   = 3;

  localparam int IN_COORD_W  = 5;
  localparam int SAMPLE_W    = 32;
  localparam int SCALE_W     = 32;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd5461;

  localparam int COORD_W     = $clog2(GRID_SIDE);
  localparam int ADDR_W      = COORD_W * GRID_DIMS;
  localparam int GRID_DEPTH  = 2 ** ADDR_W;

  // One center read plus four neighbor reads for every axis.
  localparam int NTAPS       = 1 + 4 * GRID_DIMS;
  localparam int TAP_W       = $clog2(NTAPS);

  // The weighted sum stays below 192 * 2^31 in magnitude for up to three axes.
  localparam int ACC_W       = 40;
  localparam int MAG_W       = 40;
  localparam int PROD_W      = MAG_W + 16;
  localparam int Q_W         = PROD_W + 1;

  typedef logic signed [ACC_W-1:0] acc_t;
  localparam acc_t CENTER_WEIGHT = acc_t'(30 * GRID_DIMS);

  typedef logic [2:0][COORD_W-1:0] coords_t;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    TAP_FAR,
    TAP_NEAR,
    TAP_CENTER
  } tap_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_ABS,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_FIN
  } back_state_e;

  typedef struct packed {
    op_e                        op;
    coords_t                    coords;
    logic signed [SAMPLE_W-1:0] sample;
  } cmd_t;

  // Reduces an input coordinate into the grid; a 5-bit input is always below GRID_SIDE, so no subtraction is needed.
  function automatic logic [COORD_W-1:0] mod_side(input logic [IN_COORD_W-1:0] c);
    logic [IN_COORD_W-1:0] r;
    r = c;
    for (int i = 0; i < 8; i++) begin
      if (int'(r) >= GRID_SIDE) r = r - IN_COORD_W'(GRID_SIDE);
    end
    return COORD_W'(r);
  endfunction

  // Neighbor coordinate for offsets -2, -1, +1, +2 (sel 0 to 3), wrapped around the edge.
  function automatic logic [COORD_W-1:0] wrap_coord(input logic [COORD_W-1:0] c,
                                                     input logic [1:0] sel);
    logic [COORD_W+1:0] base;
    logic [COORD_W+1:0] v;
    case (sel)
      2'd0:    base = (COORD_W+2)'(GRID_SIDE - 2);
      2'd1:    base = (COORD_W+2)'(GRID_SIDE - 1);
      2'd2:    base = (COORD_W+2)'(GRID_SIDE + 1);
      default: base = (COORD_W+2)'(GRID_SIDE + 2);
    endcase
    v = (COORD_W+2)'(c) + base;
    if (v >= (COORD_W+2)'(2 * GRID_SIDE)) begin
      v = v - (COORD_W+2)'(2 * GRID_SIDE);
    end else if (v >= (COORD_W+2)'(GRID_SIDE)) begin
      v = v - (COORD_W+2)'(GRID_SIDE);
    end
    return COORD_W'(v);
  endfunction

  // The first coordinate is the most significant address digit.
  function automatic logic [ADDR_W-1:0] cell_addr(input coords_t c);
    logic [ADDR_W-1:0] a;
    a = '0;
    for (int i = 0; i < GRID_DIMS; i++) begin
      a = (a << COORD_W) | ADDR_W'(c[i]);
    end
    return a;
  endfunction

endpackage

// ===== rtl/core/pgl_in_if.sv =====
// Input channel carrying write and query beats.
interface pgl_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic [4:0]         coord_x;
  logic [4:0]         coord_y;
  logic [4:0]         coord_z;
  logic signed [31:0] sample;

  modport source(output valid, op, coord_x, coord_y, coord_z, sample, input ready);
  modport sink(input valid, op, coord_x, coord_y, coord_z, sample, output ready);
endinterface

// ===== rtl/core/pgl_out_if.sv =====
// Output channel carrying Laplacian result beats.
interface pgl_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] lap_value;
  logic               saturated;

  modport source(output valid, lap_value, saturated, input ready);
  modport sink(input valid, lap_value, saturated, output ready);
endinterface

// ===== rtl/core/periodic_grid_laplacian_stencil_core.sv =====
// Top level of the periodic grid fourth-order Laplacian core.
// A write beat is handled by the back end in its idle state; writes sustain one beat per cycle
// while no query is in progress. A query walks the stencil taps with one grid memory read per
// tap, then passes through the drain, magnitude, low and high multiply and finish states; the
// finish state holds until the output is free. Reset clears the control state and sets the
// scale to 5461; the grid contents stay undefined until written, and there is no clearing pass.
module periodic_grid_laplacian_stencil_core import pgl_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  pgl_in_if.sink             in_i,
  pgl_out_if.source          out_o,
  input  logic               cfg_we_i,
  input  logic [SCALE_W-1:0] cfg_wdata_i
);

  logic [SCALE_W-1:0] scale_q;
  cmd_t               cmd;
  logic               cmd_valid;
  logic               cmd_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_RESET;
    end else if (cfg_we_i) begin
      scale_q <= cfg_wdata_i;
    end
  end

  pgl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop)
  );

  pgl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .scale_i     (scale_q),
    .out_o       (out_o)
  );

endmodule

// ===== rtl/core/pgl_ram.sv =====
// Generic single-port RAM with registered read data.
module pgl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ===== rtl/core/pgl_front.sv =====
// Front end: accepts input beats, reduces coordinates and queues commands.
module pgl_front import pgl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  pgl_in_if.sink    in_i,
  output cmd_t      cmd_o,
  output logic      cmd_valid_o,
  input  logic      cmd_pop_i
);

  cmd_t       in_cmd;
  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  logic       pop;

  always_comb begin
    in_cmd.op        = op_e'(in_i.op);
    in_cmd.coords[0] = mod_side(in_i.coord_x);
    in_cmd.coords[1] = mod_side(in_i.coord_y);
    in_cmd.coords[2] = mod_side(in_i.coord_z);
    in_cmd.sample    = in_i.sample;
  end

  assign in_i.ready  = (cnt_q != 2'd2);
  assign push        = in_i.valid && in_i.ready;
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= in_cmd;
    end
  end

endmodule

// ===== rtl/core/pgl_back.sv =====
// Back end: performs grid writes, walks the stencil taps, scales and saturates.
module pgl_back import pgl_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  input  logic               cmd_valid_i,
  output logic               cmd_pop_o,
  input  logic [SCALE_W-1:0] scale_i,
  pgl_out_if.source          out_o
);

  back_state_e state_q, state_d;

  logic [TAP_W-1:0]   tap_q, tap_d;
  logic [TAP_W-1:0]   tap_m1;
  logic [1:0]         axis;
  logic [1:0]         sel;
  coords_t            cmd_coords_q;
  coords_t            tap_coords;
  tap_e               tap_code;
  logic               rd_vld_q;
  tap_e               rd_tap_q;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_addr;
  logic [SAMPLE_W-1:0] ram_rdata;

  logic               start_query;
  logic               tap_inc;
  logic               out_free;
  logic               out_load;

  acc_t               acc_q;
  acc_t               rd_ext;
  acc_t               term;
  logic               neg_q;
  logic [MAG_W-1:0]   mag_q;
  logic [PROD_W-1:0]  lo_q;
  logic [PROD_W-1:0]  hi_q;

  logic [Q_W-1:0]     q_sum;
  logic [Q_W-1:0]     m_sum;
  logic               rem;
  logic [SAMPLE_W-1:0] res_value;
  logic               res_sat;

  logic               out_valid_q;
  logic [SAMPLE_W-1:0] out_value_q;
  logic               out_sat_q;

  pgl_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (GRID_DEPTH)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (cmd_i.sample),
    .rdata_o (ram_rdata)
  );

  // Tap 0 is the center cell; then four neighbors per axis, offsets -2, -1, +1, +2.
  always_comb begin
    tap_m1     = tap_q - TAP_W'(1);
    axis       = 2'(tap_m1 >> 2);
    sel        = tap_m1[1:0];
    tap_coords = cmd_coords_q;
    if (tap_q == '0) begin
      tap_code = TAP_CENTER;
    end else begin
      tap_coords[axis] = wrap_coord(cmd_coords_q[axis], sel);
      tap_code         = (sel == 2'd0 || sel == 2'd3) ? TAP_FAR : TAP_NEAR;
    end
  end

  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (cmd_valid_i && cmd_i.op == OP_QUERY) state_d = ST_READ;
      ST_READ:   if (tap_q == TAP_W'(NTAPS - 1)) state_d = ST_DRAIN;
      ST_DRAIN:  state_d = ST_ABS;
      ST_ABS:    state_d = ST_MUL_LO;
      ST_MUL_LO: state_d = ST_MUL_HI;
      ST_MUL_HI: state_d = ST_FIN;
      ST_FIN:    if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop_o   = 1'b0;
    ram_we      = 1'b0;
    ram_addr    = cell_addr(cmd_i.coords);
    start_query = 1'b0;
    tap_inc     = 1'b0;
    out_load    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.op == OP_WRITE) begin
            ram_we = 1'b1;
          end else begin
            start_query = 1'b1;
          end
        end
      end
      ST_READ: begin
        ram_addr = cell_addr(tap_coords);
        tap_inc  = 1'b1;
      end
      ST_FIN:  out_load = out_free;
      default: ;
    endcase
  end

  assign tap_d = start_query ? '0 : (tap_inc ? tap_q + TAP_W'(1) : tap_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tap_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      tap_q    <= tap_d;
      rd_vld_q <= tap_inc;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Weighted contribution of the sample returned by the grid memory.
  always_comb begin
    rd_ext = acc_t'($signed(ram_rdata));
    case (rd_tap_q)
      TAP_FAR:    term = -rd_ext;
      TAP_NEAR:   term = rd_ext <<< 4;
      TAP_CENTER: term = -(rd_ext * CENTER_WEIGHT);
      default:    term = '0;
    endcase
  end

  // The product is rounded toward minus infinity, so a negative value with a
  // nonzero remainder grows by one in magnitude.
  always_comb begin
    q_sum = Q_W'(hi_q) + Q_W'(lo_q >> 16);
    rem   = |lo_q[15:0];
    m_sum = q_sum + Q_W'(rem);
    if (!neg_q) begin
      res_sat   = q_sum > Q_W'(32'h7FFF_FFFF);
      res_value = res_sat ? 32'h7FFF_FFFF : SAMPLE_W'(q_sum);
    end else begin
      res_sat   = m_sum > Q_W'(32'h8000_0000);
      res_value = res_sat ? 32'h8000_0000 : SAMPLE_W'(Q_W'(0) - m_sum);
    end
  end

  always_ff @(posedge clk_i) begin
    rd_tap_q <= tap_code;
    if (start_query) begin
      cmd_coords_q <= cmd_i.coords;
      acc_q        <= '0;
    end else if (rd_vld_q) begin
      acc_q <= acc_q + term;
    end
    if (state_q == ST_ABS) begin
      neg_q <= acc_q[ACC_W-1];
      mag_q <= MAG_W'(acc_q[ACC_W-1] ? -acc_q : acc_q);
    end
    if (state_q == ST_MUL_LO) begin
      lo_q <= mag_q * scale_i[15:0];
    end
    if (state_q == ST_MUL_HI) begin
      hi_q <= mag_q * scale_i[31:16];
    end
    if (out_load) begin
      out_value_q <= res_value;
      out_sat_q   <= res_sat;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.lap_value = out_value_q;
  assign out_o.saturated = out_sat_q;

  // Read data only arrives for addresses issued during the tap walk.
  a_rd_from_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> $past(state_q) == ST_READ)
    else $error("grid read data without a preceding tap read");

  // All tap reads are folded into the sum before the magnitude is taken.
  a_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ABS |-> !rd_vld_q)
    else $error("tap read still pending when the sum is used");

  // A result is only produced after the last tap of a walk.
  a_walk_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DRAIN |-> $past(tap_q) == TAP_W'(NTAPS - 1))
    else $error("tap walk ended early");

  // A pending result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !out_valid_q || out_o.ready)
    else $error("result register overwritten");

endmodule
